>>> hdl/complementary_tilt_filter_top_assert.svh
// Assertion helpers used by the tilt filter top RTL.
// Every check is clocked on aclk and held off while aresetn is low.
`ifndef COMPLEMENTARY_TILT_FILTER_TOP_ASSERT_SVH
`define COMPLEMENTARY_TILT_FILTER_TOP_ASSERT_SVH

// Same-cycle implication.
`define CTF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CTF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ctf_pkg.sv
package ctf_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int NUM_FIELDS       = 9;

    // register indexes on the write port
    localparam logic [1:0] REG_ENABLE        = 2'd0;
    localparam logic [1:0] REG_BLEND_GAIN    = 2'd1;
    localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd2;

    localparam logic [15:0] BLEND_GAIN_RST    = 16'd64225;
    localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd1311;

    // mixing coefficients, unsigned Q0.16 (17 bits so that 1.0 fits)
    localparam logic [16:0] MIX_DIAG = 17'd46341;
    localparam logic [16:0] MIX_HALF = 17'd32768;
    localparam logic [16:0] GAIN_ONE = 17'h10000;

    localparam int ROUND_HALF = 32768;

    typedef struct packed {
        logic start;   // begin a blend, frame registers valid from next cycle
        logic seed;    // load the estimate from seed_value
        logic ack;     // result taken by the merge stage
    } lane_ctl_t;

endpackage

>>> hdl/complementary_tilt_filter_top.sv
// First-order complementary filter for two tilt angles over a nine-sample
// frame in signed Q3.12 (angles, body rates, auxiliary samples). While
// disabled, or on the first frame after enabling or a restart, frames pass
// through untouched and seed the estimates; otherwise angles two and three
// are blended as alpha*(estimate + period*mix(rates)) + (1-alpha)*measured
// with saturation, angle one reads zero and everything else passes through.
// A filtered frame is launched into the lanes, runs four multiply steps in
// each lane's single shared multiplier and then moves into the output
// register; a pass-through frame moves into the output register directly.
// The two angle lanes run in lockstep. Results sit in an output
// register, so a new transaction is taken while the last result waits, but
// a finished frame holds the lanes until the output register frees up.
// Configuration writes are expected only while no frame is in flight.
module complementary_tilt_filter_top
    import ctf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    localparam int FW = NUM_FIELDS * SAMPLE_WIDTH,
    localparam int DW = ((FW + 7) / 8) * 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    // config write port
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_wdata,
    // input frame
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // low to high: angle_one, angle_two, angle_three, rate_one, rate_two,
    // rate_three, aux_one, aux_two, aux_three, zero pad
    input  logic [DW-1:0] s_axis_tdata,
    // bit 0: restart
    input  logic [0:0]    s_axis_tuser,
    // result frame
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // low to high: out_angle_one, out_angle_two, out_angle_three,
    // out_rate_one, out_rate_two, out_rate_three, out_aux_one,
    // out_aux_two, out_aux_three, zero pad
    output logic [DW-1:0] m_axis_tdata
);

    localparam int W  = SAMPLE_WIDTH;
    localparam int AW = W + 4;

    // config registers
    logic        enable_reg, enable_next;
    logic [15:0] gain_reg, gain_next;
    logic [15:0] period_reg, period_next;
    logic        first_pending_reg, first_pending_next;

    // frame in flight
    logic          busy_reg, busy_next;
    logic          filt_reg, filt_next;
    logic [FW-1:0] frame_reg, frame_next;

    logic accept;
    logic filter_now;
    logic out_free;
    logic load;
    logic done_two, done_three;
    logic signed [W-1:0] est_two, est_three;
    lane_ctl_t lane_ctl;

    logic signed [W-1:0]  in_angle_two, in_angle_three;
    logic signed [W-1:0]  rate_one, rate_two, rate_three;
    logic signed [AW-1:0] r1_ext, r2_ext, r3_ext;
    logic signed [AW-1:0] diff_two, diff_three;

    assign s_axis_tready = !busy_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign filter_now    = enable_reg && !first_pending_reg && !s_axis_tuser[0];

    // finished frame moves to the output register once both lanes are done
    assign load = busy_reg && (!filt_reg || (done_two && done_three)) && out_free;

    assign in_angle_two   = s_axis_tdata[2*W-1:W];
    assign in_angle_three = s_axis_tdata[3*W-1:2*W];

    // rate mixing inputs, taken from the held frame
    assign rate_one   = frame_reg[4*W-1:3*W];
    assign rate_two   = frame_reg[5*W-1:4*W];
    assign rate_three = frame_reg[6*W-1:5*W];
    assign r1_ext     = {{4{rate_one[W-1]}}, rate_one};
    assign r2_ext     = {{4{rate_two[W-1]}}, rate_two};
    assign r3_ext     = {{4{rate_three[W-1]}}, rate_three};
    assign diff_two   = r2_ext - r1_ext;
    assign diff_three = (r3_ext <<< 1) - r1_ext - r2_ext;

    always_comb begin
        lane_ctl.start = accept && filter_now;
        lane_ctl.seed  = accept && !filter_now;
        lane_ctl.ack   = load;
    end

    always_comb begin
        enable_next        = enable_reg;
        gain_next          = gain_reg;
        period_next        = period_reg;
        first_pending_next = first_pending_reg;
        busy_next          = busy_reg;
        filt_next          = filt_reg;
        frame_next         = frame_reg;
        if (load) begin
            busy_next = 1'b0;
        end
        if (accept) begin
            busy_next          = 1'b1;
            filt_next          = filter_now;
            frame_next         = s_axis_tdata[FW-1:0];
            first_pending_next = !enable_reg;
        end
        if (cfg_we) begin
            unique case (cfg_index)
                REG_ENABLE: begin
                    enable_next = cfg_wdata[0];
                    if (!cfg_wdata[0]) begin
                        first_pending_next = 1'b1;
                    end
                end
                REG_BLEND_GAIN:    gain_next   = cfg_wdata;
                REG_SAMPLE_PERIOD: period_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg        <= 1'b0;
            gain_reg          <= BLEND_GAIN_RST;
            period_reg        <= SAMPLE_PERIOD_RST;
            first_pending_reg <= 1'b1;
            busy_reg          <= 1'b0;
            filt_reg          <= 1'b0;
        end else begin
            enable_reg        <= enable_next;
            gain_reg          <= gain_next;
            period_reg        <= period_next;
            first_pending_reg <= first_pending_next;
            busy_reg          <= busy_next;
            filt_reg          <= filt_next;
        end
        frame_reg <= frame_next;
    end

    // angle two lane: 0.7071*(rate_two - rate_one)
    ctf_lane #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_lane_two (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (lane_ctl),
        .seed_value (in_angle_two),
        .diff       (diff_two),
        .meas       (frame_reg[2*W-1:W]),
        .mix_coef   (MIX_DIAG),
        .period     (period_reg),
        .gain       (gain_reg),
        .done       (done_two),
        .result     (est_two)
    );

    // angle three lane: 0.5*(2*rate_three - rate_one - rate_two)
    ctf_lane #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_lane_three (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (lane_ctl),
        .seed_value (in_angle_three),
        .diff       (diff_three),
        .meas       (frame_reg[3*W-1:2*W]),
        .mix_coef   (MIX_HALF),
        .period     (period_reg),
        .gain       (gain_reg),
        .done       (done_three),
        .result     (est_three)
    );

    ctf_merge #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (load),
        .filt          (filt_reg),
        .frame         (frame_reg),
        .est_two       (est_two),
        .est_three     (est_three),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .out_free      (out_free)
    );

`include "complementary_tilt_filter_top_assert.svh"

    // lanes run in lockstep
    `CTF_ASSERT_NOW(a_lanes_lockstep, 1'b1, done_two == done_three, "lanes out of step")
    // a freshly launched blend cannot be finished on the next cycle
    `CTF_ASSERT_NEXT(a_blend_not_instant, accept && filter_now, !done_two && !load,
        "blend finished too early")
    // an accepted frame while enabled clears the first-frame flag when no config write comes in the same cycle
    `CTF_ASSERT_NEXT(a_first_cleared, accept && enable_reg && !cfg_we, !first_pending_reg,
        "first-frame flag not cleared")

endmodule

>>> hdl/ctf_lane.sv
module ctf_lane
    import ctf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    localparam int AW = SAMPLE_WIDTH + 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lane_ctl_t                      ctl,
    input  logic signed [SAMPLE_WIDTH-1:0] seed_value,
    input  logic signed [AW-1:0]           diff,
    input  logic signed [SAMPLE_WIDTH-1:0] meas,
    input  logic        [16:0]             mix_coef,
    input  logic        [15:0]             period,
    input  logic        [15:0]             gain,
    output logic                           done,
    output logic signed [SAMPLE_WIDTH-1:0] result
);

    localparam int W  = SAMPLE_WIDTH;
    localparam int BW = 18;
    localparam int PW = AW + BW;
    localparam int RW = PW + 1 - 16;

    localparam logic [1:0] STEP_MIX  = 2'd0;
    localparam logic [1:0] STEP_INC  = 2'd1;
    localparam logic [1:0] STEP_GAIN = 2'd2;
    localparam logic [1:0] STEP_MEAS = 2'd3;

    localparam logic signed [PW-1:0] HALF_P = PW'(ROUND_HALF);
    localparam logic signed [PW:0]   HALF_S = (PW + 1)'(ROUND_HALF);
    localparam logic signed [RW-1:0] SAT_HI = {{(RW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [RW-1:0] SAT_LO = {{(RW - W + 1){1'b1}}, {(W - 1){1'b0}}};

    logic [1:0]             step_reg, step_next;
    logic                   run_reg, run_next;
    logic                   done_reg, done_next;
    logic signed [W-1:0]    est_reg, est_next;
    logic signed [AW-1:0]   mix_reg, mix_next;
    logic signed [AW-1:0]   pred_reg, pred_next;
    logic signed [PW-1:0]   acc_reg, acc_next;

    logic signed [AW-1:0]   op_a;
    logic signed [BW-1:0]   op_b;
    logic signed [PW-1:0]   prod;
    logic signed [PW-1:0]   prod_rnd;
    logic signed [PW:0]     sum;
    logic signed [RW-1:0]   fin;
    logic signed [W-1:0]    fin_sat;
    logic signed [AW-1:0]   est_ext;
    logic signed [AW-1:0]   meas_ext;

    assign est_ext  = {{4{est_reg[W-1]}}, est_reg};
    assign meas_ext = {{4{meas[W-1]}}, meas};

    // one shared multiplier, operands picked by step
    always_comb begin
        unique case (step_reg)
            STEP_MIX: begin
                op_a = diff;
                op_b = {1'b0, mix_coef};
            end
            STEP_INC: begin
                op_a = mix_reg;
                op_b = {2'b00, period};
            end
            STEP_GAIN: begin
                op_a = pred_reg;
                op_b = {2'b00, gain};
            end
            default: begin
                op_a = meas_ext;
                op_b = {1'b0, GAIN_ONE - {1'b0, gain}};
            end
        endcase
    end

    assign prod     = op_a * op_b;
    assign prod_rnd = prod + HALF_P;
    assign sum      = {acc_reg[PW-1], acc_reg} + {prod[PW-1], prod} + HALF_S;
    assign fin      = $signed(sum[PW:16]);

    always_comb begin
        if (fin > SAT_HI) begin
            fin_sat = SAT_HI[W-1:0];
        end else if (fin < SAT_LO) begin
            fin_sat = SAT_LO[W-1:0];
        end else begin
            fin_sat = fin[W-1:0];
        end
    end

    always_comb begin
        step_next = step_reg;
        run_next  = run_reg;
        done_next = done_reg;
        est_next  = est_reg;
        mix_next  = mix_reg;
        pred_next = pred_reg;
        acc_next  = acc_reg;
        if (ctl.ack) begin
            done_next = 1'b0;
        end
        if (ctl.seed) begin
            est_next = seed_value;
        end
        if (ctl.start) begin
            run_next  = 1'b1;
            step_next = STEP_MIX;
            done_next = 1'b0;
        end else if (run_reg) begin
            step_next = step_reg + 2'd1;
            unique case (step_reg)
                STEP_MIX: begin
                    mix_next = $signed(prod_rnd[AW+15:16]);
                end
                STEP_INC: begin
                    pred_next = est_ext + $signed(prod_rnd[AW+15:16]);
                end
                STEP_GAIN: begin
                    acc_next = prod;
                end
                default: begin
                    est_next  = fin_sat;
                    run_next  = 1'b0;
                    done_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_MIX;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            est_reg  <= '0;
        end else begin
            step_reg <= step_next;
            run_reg  <= run_next;
            done_reg <= done_next;
            est_reg  <= est_next;
        end
        mix_reg  <= mix_next;
        pred_reg <= pred_next;
        acc_reg  <= acc_next;
    end

    assign done   = done_reg;
    assign result = est_reg;

endmodule

>>> hdl/ctf_merge.sv
module ctf_merge
    import ctf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    localparam int FW = NUM_FIELDS * SAMPLE_WIDTH,
    localparam int DW = ((FW + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  logic                           filt,
    input  logic [FW-1:0]                  frame,
    input  logic signed [SAMPLE_WIDTH-1:0] est_two,
    input  logic signed [SAMPLE_WIDTH-1:0] est_three,
    input  logic                           m_axis_tready,
    output logic                           m_axis_tvalid,
    output logic [DW-1:0]                  m_axis_tdata,
    output logic                           out_free
);

    localparam int W = SAMPLE_WIDTH;

    logic          valid_reg, valid_next;
    logic [FW-1:0] data_reg, data_next;
    logic [FW-1:0] merged;

    // filtered frame: angle one zeroed, angles two and three from the lanes
    always_comb begin
        merged = frame;
        if (filt) begin
            merged[W-1:0]     = '0;
            merged[2*W-1:W]   = est_two;
            merged[3*W-1:2*W] = est_three;
        end
    end

    assign out_free = !valid_reg || m_axis_tready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load) begin
            valid_next = 1'b1;
            data_next  = merged;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = DW'(data_reg);

endmodule
